/* design/asa_pkg.sv */
// ----------------------------------------------------------------------------
// Aligned stack allocator package
// Shared command codes, status codes, register indexes and the types that
// pass between the front and back parts of the allocator.
// ----------------------------------------------------------------------------
package asa_pkg;

  localparam logic OP_ALLOC = 1'b0;
  localparam logic OP_FREE  = 1'b1;

  localparam logic [2:0] ST_OK        = 3'd0;
  localparam logic [2:0] ST_NO_SPACE  = 3'd1;
  localparam logic [2:0] ST_ZERO_SIZE = 3'd2;
  localparam logic [2:0] ST_EMPTY     = 3'd3;
  localparam logic [2:0] ST_FULL      = 3'd4;

  localparam int CFG_IDX_W = 1;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = 1'b0;
  localparam logic [CFG_IDX_W-1:0] CFG_REGION_SIZE  = 1'b1;

  typedef struct packed {
    logic        is_free;
    logic        zero_size;
    logic [31:0] alloc_size;
    logic [2:0]  align_log2;
    logic [31:0] free_address;
  } cmd_t;

  typedef struct packed {
    logic valid;
    cmd_t cmd;
  } queue_head_t;

endpackage

/* design/aligned_stack_allocator_core.sv */
// Each item is popped from the front queue when idle, evaluated, then committed to the output.
// A new item is taken only after the last has passed through the pop, evaluate and commit sequence
// of the back end, whose evaluate step also performs the registered stack read.
// The two-entry front queue keeps accepting, until it is full, while a result waits on the output.
// Reset (synchronous, active low) clears the queue, the top offset, the live count
// and both configuration registers; the adjustment stack needs no clearing.
// ----------------------------------------------------------------------------
// Aligned stack allocator core
// LIFO bump allocator that grants aligned blocks with a header gap and rolls
// the top back on free, using a front queue and a back-end executor.
// ----------------------------------------------------------------------------
module aligned_stack_allocator_core import asa_pkg::*; #(
  parameter int MAX_LIVE     = 64,
  parameter int HEADER_BYTES = 1,
  parameter int ADDR_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [31:0]          in_alloc_size,
  input  logic [2:0]           in_align_log2,
  input  logic [31:0]          in_free_address,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_address,
  output logic [2:0]           out_status,
  output logic [31:0]          out_used_bytes,
  output logic [6:0]           out_live_count
);

  queue_head_t head;
  logic        pop;

  asa_front u_front (
    .clk             (clk),
    .rst_n           (rst_n),
    .in_valid        (in_valid),
    .in_stall        (in_stall),
    .in_opcode       (in_opcode),
    .in_alloc_size   (in_alloc_size),
    .in_align_log2   (in_align_log2),
    .in_free_address (in_free_address),
    .head            (head),
    .pop             (pop)
  );

  asa_back #(
    .MAX_LIVE     (MAX_LIVE),
    .HEADER_BYTES (HEADER_BYTES),
    .ADDR_BITS    (ADDR_BITS)
  ) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .head           (head),
    .pop            (pop),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_status     (out_status),
    .out_used_bytes (out_used_bytes),
    .out_live_count (out_live_count)
  );

endmodule

/* design/asa_front.sv */
// ----------------------------------------------------------------------------
// Allocator front end
// Accepts items, classifies them into commands and holds them in a
// two-entry queue for the back end.
// ----------------------------------------------------------------------------
module asa_front import asa_pkg::*; (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic        in_opcode,
  input  logic [31:0] in_alloc_size,
  input  logic [2:0]  in_align_log2,
  input  logic [31:0] in_free_address,
  output queue_head_t head,
  input  logic        pop
);

  cmd_t       q_mem_r [2];
  logic       wr_ptr_r;
  logic       rd_ptr_r;
  logic [1:0] q_count_r;
  logic [1:0] q_count_nxt;
  logic       push;
  cmd_t       cmd_in;

  always_comb begin
    cmd_in.is_free      = (in_opcode == OP_FREE);
    cmd_in.zero_size    = (in_alloc_size == 32'd0);
    cmd_in.alloc_size   = in_alloc_size;
    cmd_in.align_log2   = in_align_log2;
    cmd_in.free_address = in_free_address;
  end

  assign in_stall = (q_count_r == 2'd2);
  assign push     = in_valid && !in_stall;

  assign head.valid = (q_count_r != 2'd0);
  assign head.cmd   = q_mem_r[rd_ptr_r];

  always_comb begin
    q_count_nxt = q_count_r;
    if (push && !pop) begin
      q_count_nxt = q_count_r + 2'd1;
    end else if (pop && !push) begin
      q_count_nxt = q_count_r - 2'd1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r  <= 1'b0;
      rd_ptr_r  <= 1'b0;
      q_count_r <= 2'd0;
    end else begin
      q_count_r <= q_count_nxt;
      if (push) begin
        wr_ptr_r <= !wr_ptr_r;
      end
      if (pop) begin
        rd_ptr_r <= !rd_ptr_r;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      q_mem_r[wr_ptr_r] <= cmd_in;
    end
  end

  a_pop_when_filled: assert property (@(posedge clk) disable iff (!rst_n)
    pop |-> (q_count_r != 2'd0))
    else $error("Queue popped while empty.");

endmodule

/* design/asa_back.sv */
// ----------------------------------------------------------------------------
// Allocator back end
// Executes queued commands against the top offset, the live count and the
// adjustment stack, and holds the result in an output register.
// ----------------------------------------------------------------------------
module asa_back import asa_pkg::*; #(
  parameter int MAX_LIVE     = 64,
  parameter int HEADER_BYTES = 1,
  parameter int ADDR_BITS    = 32
) (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  queue_head_t          head,
  output logic                 pop,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic [31:0]          out_address,
  output logic [2:0]           out_status,
  output logic [31:0]          out_used_bytes,
  output logic [6:0]           out_live_count
);

  localparam int IW = (MAX_LIVE > 1) ? $clog2(MAX_LIVE) : 1;
  localparam int LW = $clog2(MAX_LIVE + 1);
  localparam int CW = (ADDR_BITS > 32) ? ADDR_BITS : 32;
  localparam logic [8:0] HDR = 9'(HEADER_BYTES);

  localparam logic [1:0] S_IDLE   = 2'd0;
  localparam logic [1:0] S_EVAL   = 2'd1;
  localparam logic [1:0] S_COMMIT = 2'd2;

  logic [1:0]           state_r;
  logic [1:0]           state_nxt;
  logic [31:0]          base_r;
  logic [31:0]          region_r;
  logic [31:0]          top_r;
  logic [31:0]          top_nxt;
  logic [LW-1:0]        live_r;
  logic [LW-1:0]        live_nxt;
  cmd_t                 cmd_r;
  logic [ADDR_BITS-1:0] cur_r;
  logic [7:0]           adj_r;
  logic [7:0]           pop_adj_r;
  logic [7:0]           stack_mem [MAX_LIVE];

  logic                 out_valid_r;
  logic [31:0]          out_address_r;
  logic [2:0]           out_status_r;
  logic [31:0]          out_used_bytes_r;
  logic [6:0]           out_live_count_r;

  logic [ADDR_BITS-1:0] cur_sum;
  logic [6:0]           align_mask;
  logic [6:0]           gap_lo;
  logic [8:0]           steps;
  logic [7:0]           adj_calc;
  logic [33:0]          need;
  logic                 fits;
  logic [ADDR_BITS-1:0] grant_addr;
  logic [ADDR_BITS-1:0] target;
  logic                 roll_ok;
  logic                 stack_full;
  logic                 stack_empty;
  logic                 out_free;
  logic                 commit;
  logic                 push;
  logic [2:0]           res_status;
  logic [31:0]          res_address;

  assign cur_sum    = ADDR_BITS'(base_r) + ADDR_BITS'(top_r);
  assign align_mask = 7'((8'd1 << cmd_r.align_log2) - 8'd1);
  assign gap_lo     = (7'd0 - cur_sum[6:0]) & align_mask;

  always_comb begin
    steps    = 9'd0;
    adj_calc = 8'(gap_lo);
    if (9'(gap_lo) < HDR) begin
      steps    = (HDR - 9'(gap_lo) + 9'(align_mask)) >> cmd_r.align_log2;
      adj_calc = 8'(9'(gap_lo) + (steps << cmd_r.align_log2));
    end
  end

  assign need        = 34'(top_r) + 34'(adj_r) + 34'(cmd_r.alloc_size);
  assign fits        = (need <= 34'(region_r));
  assign grant_addr  = cur_r + ADDR_BITS'(adj_r);
  assign target      = ADDR_BITS'(cmd_r.free_address) - ADDR_BITS'(base_r)
                       - ADDR_BITS'(pop_adj_r);
  assign roll_ok     = (CW'(target) <= CW'(top_r));
  assign stack_full  = (live_r >= LW'(MAX_LIVE));
  assign stack_empty = (live_r == '0);
  assign out_free    = !out_valid_r || !out_stall;
  assign commit      = (state_r == S_COMMIT) && out_free;
  assign pop         = (state_r == S_IDLE) && head.valid;

  always_comb begin
    res_status  = ST_OK;
    res_address = 32'd0;
    top_nxt     = top_r;
    live_nxt    = live_r;
    push        = 1'b0;
    if (!cmd_r.is_free) begin
      if (cmd_r.zero_size) begin
        res_status = ST_ZERO_SIZE;
      end else if (stack_full) begin
        res_status = ST_FULL;
      end else if (!fits) begin
        res_status = ST_NO_SPACE;
      end else begin
        push        = 1'b1;
        top_nxt     = need[31:0];
        live_nxt    = live_r + LW'(1);
        res_address = 32'(grant_addr);
      end
    end else begin
      if (stack_empty) begin
        res_status = ST_EMPTY;
      end else begin
        live_nxt = live_r - LW'(1);
        if (roll_ok) begin
          top_nxt = 32'(target);
        end
      end
    end
  end

  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (head.valid) begin
          state_nxt = S_EVAL;
        end
      end
      S_EVAL: begin
        state_nxt = S_COMMIT;
      end
      S_COMMIT: begin
        if (out_free) begin
          state_nxt = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_IDLE;
      base_r      <= 32'd0;
      region_r    <= 32'd0;
      top_r       <= 32'd0;
      live_r      <= '0;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_wr_en) begin
        case (cfg_index)
          CFG_BASE_ADDRESS: base_r   <= cfg_wr_data;
          CFG_REGION_SIZE:  region_r <= cfg_wr_data;
          default: ;
        endcase
      end
      if (commit) begin
        top_r       <= top_nxt;
        live_r      <= live_nxt;
        out_valid_r <= 1'b1;
      end else if (!out_stall) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      cmd_r <= head.cmd;
    end
    if (state_r == S_EVAL) begin
      cur_r     <= cur_sum;
      adj_r     <= adj_calc;
      pop_adj_r <= stack_mem[IW'(live_r - LW'(1))];
    end
    if (commit && push) begin
      stack_mem[IW'(live_r)] <= adj_r;
    end
    if (commit) begin
      out_address_r    <= res_address;
      out_status_r     <= res_status;
      out_used_bytes_r <= top_nxt;
      out_live_count_r <= 7'(live_nxt);
    end
  end

  assign out_valid      = out_valid_r;
  assign out_address    = out_address_r;
  assign out_status     = out_status_r;
  assign out_used_bytes = out_used_bytes_r;
  assign out_live_count = out_live_count_r;

  a_live_bound: assert property (@(posedge clk) disable iff (!rst_n)
    live_r <= LW'(MAX_LIVE))
    else $error("Live count exceeds the stack depth.");

  a_result_from_commit: assert property (@(posedge clk) disable iff (!rst_n)
    $rose(out_valid_r) |-> ($past(state_r) == S_COMMIT))
    else $error("Result appeared without a commit.");

  a_eval_after_idle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_EVAL) |-> ($past(state_r) == S_IDLE))
    else $error("Evaluation started without a queue pop.");

  a_push_counts: assert property (@(posedge clk) disable iff (!rst_n)
    (commit && push) |=> (live_r == $past(live_r) + LW'(1)))
    else $error("Granted allocation did not raise the live count.");

endmodule

/* dv/asa_checker.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aligned stack allocator checker
// Watches the configuration port and both item channels of the allocator,
// predicts the reply to every accepted request from its own copy of the
// allocator state, and compares every accepted reply with the oldest
// prediction. It also exposes the predicted newest live block so that the
// stimulus can free blocks in proper order.
// ----------------------------------------------------------------------------
module asa_checker import asa_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [31:0]          cfg_wr_data,
  input  logic                 in_valid,
  input  logic                 in_stall,
  input  logic                 in_opcode,
  input  logic [31:0]          in_alloc_size,
  input  logic [2:0]           in_align_log2,
  input  logic [31:0]          in_free_address,
  input  logic                 out_valid,
  input  logic                 out_stall,
  input  logic [31:0]          out_address,
  input  logic [2:0]           out_status,
  input  logic [31:0]          out_used_bytes,
  input  logic [6:0]           out_live_count,
  output int                   fail_count,
  output int                   outstanding,
  output logic [6:0]           live_hint,
  output logic [31:0]          top_block_addr
);

  localparam int LIVE_LIMIT   = 64;
  localparam int HEADER_MIN   = 1;
  localparam int REPORT_LIMIT = 10;

  typedef struct packed {
    logic [31:0] address;
    logic [2:0]  status;
    logic [31:0] used_bytes;
    logic [6:0]  live_count;
  } reply_t;

  logic [31:0] base_q;
  logic [31:0] region_q;
  logic [31:0] top_q;
  logic [6:0]  live_q;
  logic [7:0]  gap_stack [LIVE_LIMIT];
  logic [31:0] block_addr [LIVE_LIMIT];
  reply_t      predicted_replies [$];
  int          errors;

  initial begin
    fail_count     = 0;
    outstanding    = 0;
    live_hint      = '0;
    top_block_addr = '0;
    errors         = 0;
    base_q         = '0;
    region_q       = '0;
    top_q          = '0;
    live_q         = '0;
  end

  function automatic logic [31:0] header_gap(input logic [31:0] addr, input logic [2:0] al);
    logic [31:0] align;
    logic [31:0] gap;
    align = 32'd1 << al;
    gap   = (align - (addr & (align - 32'd1))) & (align - 32'd1);
    while (gap < HEADER_MIN) gap = gap + align;
    return gap;
  endfunction

  task automatic serve_request(input logic op, input logic [31:0] size, input logic [2:0] al,
                               input logic [31:0] faddr, output reply_t r);
    logic [31:0] cur;
    logic [31:0] gap;
    logic [31:0] target;
    logic [33:0] need;
    r = '0;
    if (op == OP_ALLOC) begin
      if (size == '0) begin
        r.status = ST_ZERO_SIZE;
      end else if (live_q >= LIVE_LIMIT) begin
        r.status = ST_FULL;
      end else begin
        cur  = base_q + top_q;
        gap  = header_gap(cur, al);
        need = {2'b00, top_q} + {2'b00, gap} + {2'b00, size};
        if (need > {2'b00, region_q}) begin
          r.status = ST_NO_SPACE;
        end else begin
          gap_stack[live_q]  = gap[7:0];
          block_addr[live_q] = cur + gap;
          live_q             = live_q + 7'd1;
          top_q              = need[31:0];
          r.address          = cur + gap;
          r.status           = ST_OK;
        end
      end
    end else if (live_q == '0) begin
      r.status = ST_EMPTY;
    end else begin
      live_q = live_q - 7'd1;
      target = faddr - base_q - {24'd0, gap_stack[live_q]};
      if (target <= top_q) top_q = target;
      r.status = ST_OK;
    end
    r.used_bytes = top_q;
    r.live_count = live_q;
  endtask

  always @(posedge clk) begin
    reply_t want;
    reply_t got;
    if (!rst_n) begin
      base_q   = '0;
      region_q = '0;
      top_q    = '0;
      live_q   = '0;
      predicted_replies.delete();
    end else begin
      if (cfg_wr_en) begin
        if (cfg_index == CFG_BASE_ADDRESS) base_q = cfg_wr_data;
        else if (cfg_index == CFG_REGION_SIZE) region_q = cfg_wr_data;
      end
      if (in_valid && !in_stall) begin
        serve_request(in_opcode, in_alloc_size, in_align_log2, in_free_address, want);
        predicted_replies.push_back(want);
      end
      if (out_valid && !out_stall) begin
        got = {out_address, out_status, out_used_bytes, out_live_count};
        if (predicted_replies.size() == 0) begin
          errors = errors + 1;
          if (errors <= REPORT_LIMIT)
            $display("%0t: unexpected item: address %h status %0d used %h live %0d",
                     $realtime, got.address, got.status, got.used_bytes, got.live_count);
        end else begin
          want = predicted_replies.pop_front();
          if (got.address !== want.address || got.status !== want.status ||
              got.used_bytes !== want.used_bytes || got.live_count !== want.live_count) begin
            errors = errors + 1;
            if (errors <= REPORT_LIMIT) begin
              $write("%0t: mismatch: expected address %h status %0d used %h live %0d, ",
                     $realtime, want.address, want.status, want.used_bytes,
                     want.live_count);
              $display("got address %h status %0d used %h live %0d",
                       got.address, got.status, got.used_bytes, got.live_count);
            end
          end
        end
      end
    end
    fail_count     <= errors;
    outstanding    <= predicted_replies.size();
    live_hint      <= live_q;
    top_block_addr <= (live_q == '0) ? 32'd0 : block_addr[live_q - 7'd1];
  end

endmodule

/* dv/tb_top.sv */
`timescale 1ns / 100ps
// ----------------------------------------------------------------------------
// Aligned stack allocator testbench
// Drives configuration and request items into the allocator core: a directed
// pass over the special cases, then random phases over several region
// settings and idling patterns. A checker beside the core predicts and
// compares every reply; this module only makes stimulus and gives the verdict.
// ----------------------------------------------------------------------------
module tb_top;
  import asa_pkg::*;

  typedef enum int {IDLE_NONE, IDLE_SENDER, IDLE_RECEIVER, IDLE_BOTH} idle_mode_t;

  localparam int QUIET_LIMIT = 5000;
  localparam int SETTLE      = 8;

  logic                 clk             = 1'b0;
  logic                 rst_n           = 1'b0;
  logic                 cfg_wr_en       = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index       = CFG_BASE_ADDRESS;
  logic [31:0]          cfg_wr_data     = '0;
  logic                 in_valid        = 1'b0;
  logic                 in_stall;
  logic                 in_opcode       = OP_ALLOC;
  logic [31:0]          in_alloc_size   = '0;
  logic [2:0]           in_align_log2   = '0;
  logic [31:0]          in_free_address = '0;
  logic                 out_valid;
  logic                 out_stall       = 1'b0;
  logic [31:0]          out_address;
  logic [2:0]           out_status;
  logic [31:0]          out_used_bytes;
  logic [6:0]           out_live_count;

  int          fail_count;
  int          outstanding;
  logic [6:0]  live_hint;
  logic [31:0] top_block_addr;
  int          send_idle_pct  = 0;
  int          recv_stall_pct = 0;
  int          quiet_cycles   = 0;

  aligned_stack_allocator_core u_dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_alloc_size  (in_alloc_size),
    .in_align_log2  (in_align_log2),
    .in_free_address(in_free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_status     (out_status),
    .out_used_bytes (out_used_bytes),
    .out_live_count (out_live_count)
  );

  asa_checker u_checker (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_wr_en      (cfg_wr_en),
    .cfg_index      (cfg_index),
    .cfg_wr_data    (cfg_wr_data),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_opcode      (in_opcode),
    .in_alloc_size  (in_alloc_size),
    .in_align_log2  (in_align_log2),
    .in_free_address(in_free_address),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_address    (out_address),
    .out_status     (out_status),
    .out_used_bytes (out_used_bytes),
    .out_live_count (out_live_count),
    .fail_count     (fail_count),
    .outstanding    (outstanding),
    .live_hint      (live_hint),
    .top_block_addr (top_block_addr)
  );

  always #10 clk = ~clk;

  always @(posedge clk) begin
    out_stall <= ($urandom_range(0, 99) < recv_stall_pct);
  end

  always @(posedge clk) begin
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || cfg_wr_en) begin
      quiet_cycles <= 0;
    end else begin
      quiet_cycles <= quiet_cycles + 1;
    end
    if (quiet_cycles >= QUIET_LIMIT) begin
      $display("tb_top failed");
      $finish;
    end
  end

  task automatic send_item(input logic op, input logic [31:0] size, input logic [2:0] al,
                           input logic [31:0] addr, input bit follow_top);
    logic [31:0] faddr;
    faddr = addr;
    if (follow_top) begin
      in_valid <= 1'b0;
      @(posedge clk);
      faddr = top_block_addr;
    end
    while ($urandom_range(0, 99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    in_valid        <= 1'b1;
    in_opcode       <= op;
    in_alloc_size   <= size;
    in_align_log2   <= al;
    in_free_address <= faddr;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  task automatic drain_replies();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (SETTLE) @(posedge clk);
  endtask

  task automatic set_region(input logic [31:0] base, input logic [31:0] region);
    drain_replies();
    cfg_wr_en   <= 1'b1;
    cfg_index   <= CFG_BASE_ADDRESS;
    cfg_wr_data <= base;
    @(posedge clk);
    cfg_index   <= CFG_REGION_SIZE;
    cfg_wr_data <= region;
    @(posedge clk);
    cfg_wr_en   <= 1'b0;
  endtask

  task automatic send_random(input int alloc_pct, input int wide_pct);
    int          size_pick;
    logic [31:0] size;
    if ($urandom_range(0, 99) < alloc_pct) begin
      size_pick = $urandom_range(0, 99);
      if (size_pick < 8) size = '0;
      else if (size_pick < 100 - wide_pct)
        size = ($urandom_range(0, 3) == 0) ? $urandom_range(1, 4096) : $urandom_range(1, 64);
      else size = $urandom;
      send_item(OP_ALLOC, size, 3'($urandom_range(0, 7)), $urandom, 1'b0);
    end else if (live_hint != '0 && $urandom_range(0, 99) < 75) begin
      send_item(OP_FREE, $urandom, 3'($urandom_range(0, 7)), '0, 1'b1);
    end else if ($urandom_range(0, 1) == 0) begin
      send_item(OP_FREE, $urandom, 3'($urandom_range(0, 7)), $urandom, 1'b0);
    end else begin
      send_item(OP_FREE, $urandom, 3'($urandom_range(0, 7)),
                top_block_addr + $urandom_range(0, 255) - 32'd128, 1'b0);
    end
  endtask

  task automatic run_phase(input logic [31:0] base, input logic [31:0] region,
                           input idle_mode_t mode, input int count,
                           input int alloc_pct, input int wide_pct);
    set_region(base, region);
    case (mode)
      IDLE_NONE: begin
        send_idle_pct  = 0;
        recv_stall_pct = 0;
      end
      IDLE_SENDER: begin
        send_idle_pct  = 45;
        recv_stall_pct = 0;
      end
      IDLE_RECEIVER: begin
        send_idle_pct  = 0;
        recv_stall_pct = 45;
      end
      default: begin
        send_idle_pct  = 33;
        recv_stall_pct = 33;
      end
    endcase
    repeat (count) send_random(alloc_pct, wide_pct);
  endtask

  initial begin
    repeat (8) @(posedge clk);
    rst_n <= 1'b1;

    // Reset configuration: an empty region at address zero.
    send_item(OP_ALLOC, 32'd1, 3'd0, 32'd0, 1'b0);
    send_item(OP_FREE, 32'd0, 3'd0, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'd0, 3'd0, 32'd0, 1'b0);

    set_region(32'h0000_1003, 32'h0000_0200);
    send_item(OP_ALLOC, 32'd0, 3'd7, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_ALLOC, 32'd1, 3'd0, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'd5, 3'd7, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 3'd2, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'd1, 3'd3, 32'd0, 1'b0);
    send_item(OP_FREE, 32'hFFFF_FFFF, 3'd7, 32'd0, 1'b1);
    send_item(OP_FREE, 32'd0, 3'd0, 32'hFFFF_FFFF, 1'b0);
    send_item(OP_FREE, 32'd0, 3'd0, 32'h0000_0000, 1'b0);
    send_item(OP_FREE, 32'd0, 3'd0, 32'h0000_1004, 1'b0);
    send_item(OP_ALLOC, 32'h0000_0200, 3'd0, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'h0000_01FF, 3'd0, 32'd0, 1'b0);
    send_item(OP_FREE, 32'd0, 3'd0, 32'h0000_1004, 1'b0);

    set_region(32'hFFFF_FFFE, 32'hFFFF_FFFF);
    send_item(OP_ALLOC, 32'd4, 3'd2, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'hFFFF_FFFF, 3'd7, 32'd0, 1'b0);
    send_item(OP_ALLOC, 32'd1, 3'd7, 32'd0, 1'b0);
    send_item(OP_FREE, 32'd0, 3'd0, 32'd0, 1'b1);
    send_item(OP_FREE, 32'd0, 3'd0, 32'd0, 1'b1);
    send_item(OP_FREE, 32'd0, 3'd0, 32'd0, 1'b0);

    run_phase(32'h0000_1000, 32'h0000_0800, IDLE_NONE, 150, 60, 10);
    run_phase(32'hFFFF_FF80, 32'h0000_1000, IDLE_SENDER, 150, 60, 10);
    run_phase(32'h0000_0000, 32'hFFFF_FFFF, IDLE_RECEIVER, 200, 85, 0);
    run_phase(32'hFFFF_FFFF, 32'h0000_0000, IDLE_BOTH, 100, 60, 10);
    run_phase($urandom, 32'h0000_0100, IDLE_NONE, 150, 70, 10);
    run_phase($urandom, $urandom, IDLE_SENDER, 150, 55, 10);
    run_phase(32'h8000_0001, 32'h0001_0000, IDLE_RECEIVER, 150, 75, 5);
    run_phase(32'h0000_0000, 32'h0000_0400, IDLE_BOTH, 150, 60, 10);

    drain_replies();
    if (fail_count == 0) begin
      $display("tb_top passed");
    end else begin
      $display("tb_top failed");
    end
    $finish;
  end

endmodule
